FILE: hw/rtl/pdjls_pkg.sv
// Package for the packet delay / jitter / loss statistics block.
// Field widths, register defaults and parameter defaults; no dependencies.

package pdjls_pkg;

    localparam int DEF_SUM_WIDTH   = 48;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int TS_WIDTH    = 32;   // millisecond timestamps, delay, jitter
    localparam int SEQ_WIDTH   = 16;
    localparam int GAP_WIDTH   = 10;
    localparam int TOTAL_WIDTH = 48;   // delay_total / jitter_total fields
    localparam int CNT_WIDTH   = 32;   // packets_seen / lost_total fields

    localparam logic [GAP_WIDTH-1:0] GAP_RESET = GAP_WIDTH'(5);

    localparam int IN_TDATA_WIDTH  = 2 * TS_WIDTH + SEQ_WIDTH;                  // 80
    // delay, jitter and both peaks, lost_here, two totals, two counts
    localparam int OUT_TDATA_WIDTH = 4 * TS_WIDTH + SEQ_WIDTH + 2 * TOTAL_WIDTH // 304
                                     + 2 * CNT_WIDTH;

endpackage

FILE: hw/rtl/pdjls_update.sv
// Statistics state and per-packet update for the delay / jitter / loss block.
// Depends on pdjls_pkg. Outputs show values after the presented packet.

module pdjls_update #(
    parameter int SUM_WIDTH   = pdjls_pkg::DEF_SUM_WIDTH,
    parameter int COUNT_WIDTH = pdjls_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic [pdjls_pkg::TS_WIDTH-1:0]      i_arrival_ms,
    input  logic [pdjls_pkg::TS_WIDTH-1:0]      i_send_ms,
    input  logic [pdjls_pkg::SEQ_WIDTH-1:0]     i_seq_number,
    input  logic [pdjls_pkg::GAP_WIDTH-1:0]     i_expected_gap_ms,
    output logic [pdjls_pkg::TS_WIDTH-1:0]      o_delay_ms,
    output logic [pdjls_pkg::TS_WIDTH-1:0]      o_jitter_ms,
    output logic [pdjls_pkg::SEQ_WIDTH-1:0]     o_lost_here,
    output logic [COUNT_WIDTH-1:0]              o_count,
    output logic [COUNT_WIDTH-1:0]              o_loss,
    output logic [SUM_WIDTH-1:0]                o_delay_sum,
    output logic [pdjls_pkg::TS_WIDTH-1:0]      o_delay_max,
    output logic [SUM_WIDTH-1:0]                o_jitter_sum,
    output logic [pdjls_pkg::TS_WIDTH-1:0]      o_jitter_max
);
    import pdjls_pkg::*;

    localparam int SW1 = SUM_WIDTH + 1;
    localparam int CW1 = COUNT_WIDTH + 1;

    logic                   r_first;
    logic [SEQ_WIDTH-1:0]   r_prev_seq;
    logic [TS_WIDTH-1:0]    r_prev_arrival;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_loss;
    logic [SUM_WIDTH-1:0]   r_delay_sum;
    logic [TS_WIDTH-1:0]    r_delay_max;
    logic [SUM_WIDTH-1:0]   r_jitter_sum;
    logic [TS_WIDTH-1:0]    r_jitter_max;

    logic [TS_WIDTH-1:0]    w_delay;
    logic [TS_WIDTH-1:0]    w_gap;
    logic [TS_WIDTH-1:0]    w_exp;
    logic [TS_WIDTH-1:0]    w_jitter;
    logic [SEQ_WIDTH-1:0]   w_lost;
    logic [SW1-1:0]         w_dsum;
    logic [SW1-1:0]         w_jsum;
    logic [CW1-1:0]         w_lsum;

    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] n_loss;
    logic [SUM_WIDTH-1:0]   n_delay_sum;
    logic [TS_WIDTH-1:0]    n_delay_max;
    logic [SUM_WIDTH-1:0]   n_jitter_sum;
    logic [TS_WIDTH-1:0]    n_jitter_max;

    always_comb begin
        w_delay = i_arrival_ms - i_send_ms;
        w_gap   = i_arrival_ms - r_prev_arrival;
        w_exp   = TS_WIDTH'(i_expected_gap_ms);

        // first packet after reset carries no jitter and no loss
        if (r_first) begin
            w_jitter = '0;
            w_lost   = '0;
        end else begin
            w_jitter = (w_gap >= w_exp) ? (w_gap - w_exp) : (w_exp - w_gap);
            w_lost   = i_seq_number - (r_prev_seq + SEQ_WIDTH'(1));
        end

        // saturating sums: carry out of the register width pins to all ones
        w_dsum = {1'b0, r_delay_sum}  + SW1'(w_delay);
        w_jsum = {1'b0, r_jitter_sum} + SW1'(w_jitter);
        w_lsum = {1'b0, r_loss}       + CW1'(w_lost);

        n_delay_sum  = w_dsum[SUM_WIDTH] ? '1 : w_dsum[SUM_WIDTH-1:0];
        n_jitter_sum = w_jsum[SUM_WIDTH] ? '1 : w_jsum[SUM_WIDTH-1:0];
        n_loss       = w_lsum[COUNT_WIDTH] ? '1 : w_lsum[COUNT_WIDTH-1:0];
        n_count      = (&r_count) ? r_count : r_count + COUNT_WIDTH'(1);
        n_delay_max  = (w_delay > r_delay_max) ? w_delay : r_delay_max;
        n_jitter_max = (w_jitter > r_jitter_max) ? w_jitter : r_jitter_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first        <= 1'b1;
            r_prev_seq     <= '0;
            r_prev_arrival <= '0;
            r_count        <= '0;
            r_loss         <= '0;
            r_delay_sum    <= '0;
            r_delay_max    <= '0;
            r_jitter_sum   <= '0;
            r_jitter_max   <= '0;
        end else if (i_advance) begin
            r_first        <= 1'b0;
            r_prev_seq     <= i_seq_number;
            r_prev_arrival <= i_arrival_ms;
            r_count        <= n_count;
            r_loss         <= n_loss;
            r_delay_sum    <= n_delay_sum;
            r_delay_max    <= n_delay_max;
            r_jitter_sum   <= n_jitter_sum;
            r_jitter_max   <= n_jitter_max;
        end
    end

    assign o_delay_ms   = w_delay;
    assign o_jitter_ms  = w_jitter;
    assign o_lost_here  = w_lost;
    assign o_count      = n_count;
    assign o_loss       = n_loss;
    assign o_delay_sum  = n_delay_sum;
    assign o_delay_max  = n_delay_max;
    assign o_jitter_sum = n_jitter_sum;
    assign o_jitter_max = n_jitter_max;

endmodule

FILE: hw/rtl/packet_delay_jitter_loss_stats.sv
// Top level of the packet delay / jitter / loss statistics block.
// Depends on pdjls_pkg and pdjls_update.
//
// Usage:
//   Slave stream s_axis_*: one transfer per received packet, carrying the
//   arrival time, the sender time and the sequence number.
//   Master stream m_axis_*: one transfer per packet, carrying the packet's
//   delay, jitter and loss plus the running totals and peaks after it.
//   i_cfg_wr_en / i_cfg_wr_data write the expected arrival gap in ms; write
//   it only while no packet is in flight.
// Path: a packet taken from the slave side sits in the input register, and its
//   result is loaded into the output register once that register is free or
//   draining, which raises m_axis_tvalid.
// Throughput: one packet per cycle while m_axis_tready is high; the update is
//   a single pass of adds and compares between the input and output register.
// Reset (synchronous, i_rst_n low): pipeline empty, statistics cleared,
//   next packet treated as the first, expected gap back to 5 ms.
// Stall: with m_axis_tready low the output register holds its result; the
//   input register still takes one more packet, then s_axis_tready drops.

module packet_delay_jitter_loss_stats #(
    parameter int SUM_WIDTH   = pdjls_pkg::DEF_SUM_WIDTH,
    parameter int COUNT_WIDTH = pdjls_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [pdjls_pkg::GAP_WIDTH-1:0]         i_cfg_wr_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // arrival_ms[31:0], send_ms[63:32], seq_number[79:64]
    input  logic [pdjls_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // delay_ms[31:0], jitter_ms[63:32], lost_here[79:64], packets_seen[111:80],
    // lost_total[143:112], delay_total[191:144], delay_peak[223:192],
    // jitter_total[271:224], jitter_peak[303:272]
    output logic [pdjls_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata
);
    import pdjls_pkg::*;

    logic                       r_in_valid;
    logic [IN_TDATA_WIDTH-1:0]  r_in_data;
    logic                       r_out_valid;
    logic [OUT_TDATA_WIDTH-1:0] r_out_data;
    logic [GAP_WIDTH-1:0]       r_expected_gap;

    logic                       w_advance;
    logic [TS_WIDTH-1:0]        w_delay;
    logic [TS_WIDTH-1:0]        w_jitter;
    logic [SEQ_WIDTH-1:0]       w_lost;
    logic [COUNT_WIDTH-1:0]     w_count;
    logic [COUNT_WIDTH-1:0]     w_loss;
    logic [SUM_WIDTH-1:0]       w_delay_sum;
    logic [TS_WIDTH-1:0]        w_delay_max;
    logic [SUM_WIDTH-1:0]       w_jitter_sum;
    logic [TS_WIDTH-1:0]        w_jitter_max;
    logic [OUT_TDATA_WIDTH-1:0] n_out_data;

    // input register moves on whenever the output register is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;

    pdjls_update #(
        .SUM_WIDTH   (SUM_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (w_advance),
        .i_arrival_ms      (r_in_data[TS_WIDTH-1:0]),
        .i_send_ms         (r_in_data[2*TS_WIDTH-1:TS_WIDTH]),
        .i_seq_number      (r_in_data[2*TS_WIDTH+SEQ_WIDTH-1:2*TS_WIDTH]),
        .i_expected_gap_ms (r_expected_gap),
        .o_delay_ms        (w_delay),
        .o_jitter_ms       (w_jitter),
        .o_lost_here       (w_lost),
        .o_count           (w_count),
        .o_loss            (w_loss),
        .o_delay_sum       (w_delay_sum),
        .o_delay_max       (w_delay_max),
        .o_jitter_sum      (w_jitter_sum),
        .o_jitter_max      (w_jitter_max)
    );

    assign n_out_data = {w_jitter_max,
                         TOTAL_WIDTH'(w_jitter_sum),
                         w_delay_max,
                         TOTAL_WIDTH'(w_delay_sum),
                         CNT_WIDTH'(w_loss),
                         CNT_WIDTH'(w_count),
                         w_lost,
                         w_jitter,
                         w_delay};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_expected_gap <= GAP_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_expected_gap <= i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // an empty output register never blocks the slave side
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("slave side stalled with empty output register");

    // a held packet reaches a free output register in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |=> r_out_valid)
        else $error("packet did not move to output register");

    // peaks include the packet they are reported with
    a_delay_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[223:192] >= r_out_data[31:0])
        else $error("delay peak below packet delay");

    a_jitter_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[303:272] >= r_out_data[63:32])
        else $error("jitter peak below packet jitter");

endmodule

FILE: verif/pdjls_checker.sv
// Checker for the packet delay / jitter / loss statistics block.
// Watches the config port and both streams, predicts each result and compares it.
// Depends on pdjls_pkg.
`timescale 1ns / 100ps

module pdjls_checker #(
    parameter int SUM_W   = pdjls_pkg::DEF_SUM_WIDTH,
    parameter int COUNT_W = pdjls_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [pdjls_pkg::GAP_WIDTH-1:0]       i_cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // arrival_ms, send_ms, seq_number
    input  logic [pdjls_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // delay_ms, jitter_ms, lost_here, packets_seen, lost_total,
    // delay_total, delay_peak, jitter_total, jitter_peak
    input  logic [pdjls_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    output int unsigned                           o_pending,
    output int unsigned                           o_fail_count
);
    import pdjls_pkg::*;

    // Packed so that the last member lands in the lowest bits of tdata.
    typedef struct packed {
        logic [TS_WIDTH-1:0]    jitter_peak;
        logic [TOTAL_WIDTH-1:0] jitter_total;
        logic [TS_WIDTH-1:0]    delay_peak;
        logic [TOTAL_WIDTH-1:0] delay_total;
        logic [CNT_WIDTH-1:0]   lost_total;
        logic [CNT_WIDTH-1:0]   packets_seen;
        logic [SEQ_WIDTH-1:0]   lost_here;
        logic [TS_WIDTH-1:0]    jitter_ms;
        logic [TS_WIDTH-1:0]    delay_ms;
    } t_pkt_stats;

    localparam logic [64:0] SUM_LIMIT   = (65'd1 << SUM_W) - 65'd1;
    localparam logic [64:0] COUNT_LIMIT = (65'd1 << COUNT_W) - 65'd1;

    // expected results in flight; the block itself holds at most two
    localparam int DUE_AW    = 3;
    localparam int DUE_DEPTH = 1 << DUE_AW;

    logic [GAP_WIDTH-1:0] gap_cfg;
    logic                 first_pkt;
    logic [SEQ_WIDTH-1:0] last_seq;
    logic [TS_WIDTH-1:0]  last_arrival;
    logic [63:0]          pkt_count;
    logic [63:0]          loss_sum;
    logic [63:0]          delay_sum;
    logic [63:0]          delay_max;
    logic [63:0]          jitter_sum;
    logic [63:0]          jitter_max;

    t_pkt_stats           due_buf [DUE_DEPTH];
    logic [DUE_AW-1:0]    due_wr;
    logic [DUE_AW-1:0]    due_rd;
    int unsigned          due_cnt;
    t_pkt_stats           stats_got;
    t_pkt_stats           stats_want;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [64:0] limit);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > limit) ? limit[63:0] : sum[63:0];
    endfunction

    task report_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("%0t ns stats mismatch, %s: expected %0h, got %0h", $time, what, want, got);
        o_fail_count++;
    endtask

    task check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    // Takes one packet into the shadow statistics and queues the result it implies.
    task update_stats(input logic [TS_WIDTH-1:0] arrival, input logic [TS_WIDTH-1:0] sent,
                      input logic [SEQ_WIDTH-1:0] seq);
        t_pkt_stats           res;
        logic [TS_WIDTH-1:0]  delay;
        logic [TS_WIDTH-1:0]  gap;
        logic [TS_WIDTH-1:0]  jitter;
        logic [SEQ_WIDTH-1:0] lost;
        delay  = arrival - sent;
        jitter = '0;
        lost   = '0;
        if (!first_pkt) begin
            gap    = arrival - last_arrival;   // wraps when the clock runs backwards
            jitter = (gap >= TS_WIDTH'(gap_cfg)) ? gap - TS_WIDTH'(gap_cfg)
                                                 : TS_WIDTH'(gap_cfg) - gap;
            lost   = seq - (last_seq + SEQ_WIDTH'(1));
            jitter_sum = sat_add(jitter_sum, 64'(jitter), SUM_LIMIT);
            if (64'(jitter) > jitter_max)
                jitter_max = 64'(jitter);
            loss_sum = sat_add(loss_sum, 64'(lost), COUNT_LIMIT);
        end
        last_arrival = arrival;
        last_seq     = seq;
        first_pkt    = 1'b0;
        delay_sum = sat_add(delay_sum, 64'(delay), SUM_LIMIT);
        pkt_count = sat_add(pkt_count, 64'd1, COUNT_LIMIT);
        if (64'(delay) > delay_max)
            delay_max = 64'(delay);

        res.delay_ms     = delay;
        res.jitter_ms    = jitter;
        res.lost_here    = lost;
        res.packets_seen = pkt_count[CNT_WIDTH-1:0];
        res.lost_total   = loss_sum[CNT_WIDTH-1:0];
        res.delay_total  = delay_sum[TOTAL_WIDTH-1:0];
        res.delay_peak   = delay_max[TS_WIDTH-1:0];
        res.jitter_total = jitter_sum[TOTAL_WIDTH-1:0];
        res.jitter_peak  = jitter_max[TS_WIDTH-1:0];
        if (due_cnt == DUE_DEPTH) begin
            report_mismatch("more packets in flight than the block can hold",
                            64'(DUE_DEPTH), 64'(due_cnt));
        end else begin
            due_buf[due_wr] = res;
            due_wr          = due_wr + DUE_AW'(1);
            due_cnt++;
        end
    endtask

    // Output side is handled before the input side so that a result can never
    // be matched against the packet taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_cfg      = GAP_RESET;
            first_pkt    = 1'b1;
            last_seq     = '0;
            last_arrival = '0;
            pkt_count    = '0;
            loss_sum     = '0;
            delay_sum    = '0;
            delay_max    = '0;
            jitter_sum   = '0;
            jitter_max   = '0;
            due_wr       = '0;
            due_rd       = '0;
            due_cnt      = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                stats_got = m_axis_tdata;
                if (due_cnt == 0) begin
                    report_mismatch("result transfer with nothing pending", '0,
                                    m_axis_tdata[63:0]);
                end else begin
                    stats_want = due_buf[due_rd];
                    due_rd     = due_rd + DUE_AW'(1);
                    due_cnt--;
                    check_field("delay_ms", 64'(stats_want.delay_ms),
                                64'(stats_got.delay_ms));
                    check_field("jitter_ms", 64'(stats_want.jitter_ms),
                                64'(stats_got.jitter_ms));
                    check_field("lost_here", 64'(stats_want.lost_here),
                                64'(stats_got.lost_here));
                    check_field("packets_seen", 64'(stats_want.packets_seen),
                                64'(stats_got.packets_seen));
                    check_field("lost_total", 64'(stats_want.lost_total),
                                64'(stats_got.lost_total));
                    check_field("delay_total", 64'(stats_want.delay_total),
                                64'(stats_got.delay_total));
                    check_field("delay_peak", 64'(stats_want.delay_peak),
                                64'(stats_got.delay_peak));
                    check_field("jitter_total", 64'(stats_want.jitter_total),
                                64'(stats_got.jitter_total));
                    check_field("jitter_peak", 64'(stats_want.jitter_peak),
                                64'(stats_got.jitter_peak));
                end
            end
            if (i_cfg_wr_en)
                gap_cfg = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                update_stats(s_axis_tdata[TS_WIDTH-1:0],
                             s_axis_tdata[2*TS_WIDTH-1:TS_WIDTH],
                             s_axis_tdata[2*TS_WIDTH+SEQ_WIDTH-1:2*TS_WIDTH]);
        end
        o_pending = due_cnt;
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top for packet_delay_jitter_loss_stats: clock, reset, packet
// stimulus with bursty input and stalling output, and the verdict.
// Depends on pdjls_pkg, the block and pdjls_checker.
`timescale 1ns / 100ps

module tb_top;
    import pdjls_pkg::*;

    localparam int          RANDOM_PER_PHASE = 250;
    localparam int          NUM_PHASES       = 6;
    localparam int          HOLD_AFTER       = 100;    // packets sent before the long stall
    localparam int          HOLD_CYCLES      = 400;
    localparam int          DRAIN_CYCLES     = 4;
    localparam int unsigned LIMIT_CYCLES     = 300000;

    typedef enum {
        PKT_IN_ORDER, PKT_SEQ_REPEAT, PKT_SEQ_BACK, PKT_LATE_CLOCK, PKT_NOISE
    } t_pkt_kind;
    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_RARE, RDY_MOSTLY} t_rdy_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [GAP_WIDTH-1:0]       i_cfg_wr_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

    int unsigned          pending;
    int unsigned          fail_count;
    int unsigned          cycle_count = 0;
    int unsigned          sent_count = 0;
    int unsigned          burst_left;
    int unsigned          rdy_span;
    t_rdy_mode            rdy_mode;
    logic                 hold_done = 1'b0;
    logic [GAP_WIDTH-1:0] gap_now;
    logic [TS_WIDTH-1:0]  cur_arrival;
    logic [SEQ_WIDTH-1:0] cur_seq;
    logic [GAP_WIDTH-1:0] phase_gap [NUM_PHASES];

    always #5 i_clk = ~i_clk;

    packet_delay_jitter_loss_stats i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pdjls_checker u_stats_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    // tvalid stays up inside a burst, drops for a random gap between bursts.
    task automatic send_pkt(input logic [TS_WIDTH-1:0] arrival, input logic [TS_WIDTH-1:0] sent,
                            input logic [SEQ_WIDTH-1:0] seq);
        s_axis_tdata  = {seq, sent, arrival};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Register writes only once every result is out and the pipe has drained.
    task automatic set_gap(input logic [GAP_WIDTH-1:0] value);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        gap_now     = value;
    endtask

    // Mostly a plausible packet stream around the expected gap; the rest is
    // reordering, clock steps backwards and plain noise.
    task automatic stream_pkt();
        t_pkt_kind            kind;
        int unsigned          pick;
        int unsigned          wobble;
        logic [TS_WIDTH-1:0]  step;
        logic [TS_WIDTH-1:0]  sent;
        pick   = $urandom_range(0, 99);
        kind   = (pick < 70) ? PKT_IN_ORDER : (pick < 76) ? PKT_SEQ_REPEAT :
                 (pick < 82) ? PKT_SEQ_BACK : (pick < 88) ? PKT_LATE_CLOCK : PKT_NOISE;
        wobble = $urandom_range(0, 20);
        if ($urandom_range(0, 1))
            step = TS_WIDTH'(gap_now) + wobble;
        else
            step = (gap_now > wobble) ? TS_WIDTH'(gap_now) - wobble : '0;
        if ($urandom_range(0, 19) == 0)
            step += $urandom_range(100, 5000);
        case (kind)
            PKT_IN_ORDER: begin
                cur_arrival += step;
                cur_seq     += ($urandom_range(0, 9) == 0) ? SEQ_WIDTH'($urandom_range(2, 6))
                                                          : SEQ_WIDTH'(1);
            end
            PKT_SEQ_REPEAT: begin
                cur_arrival += step;
            end
            PKT_SEQ_BACK: begin
                cur_arrival += step;
                cur_seq     -= SEQ_WIDTH'($urandom_range(1, 50));
            end
            PKT_LATE_CLOCK: begin
                cur_arrival -= $urandom_range(1, 1000);
                cur_seq     += SEQ_WIDTH'(1);
            end
            default: begin
                cur_arrival = $urandom();
                cur_seq     = SEQ_WIDTH'($urandom());
            end
        endcase
        sent = (kind == PKT_NOISE) ? TS_WIDTH'($urandom())
                                   : cur_arrival - TS_WIDTH'($urandom_range(0, 400));
        send_pkt(cur_arrival, sent, cur_seq);
    endtask

    // Output side: random ready patterns, plus one long stall while the
    // sender keeps pushing so the block backs up onto its input.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!hold_done && sent_count >= HOLD_AFTER) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            rdy_mode = t_rdy_mode'($urandom_range(0, 3));
            rdy_span = $urandom_range(5, 80);
            repeat (rdy_span) begin
                case (rdy_mode)
                    RDY_ALWAYS: m_axis_tready = 1'b1;
                    RDY_HALF:   m_axis_tready = ($urandom_range(0, 1) == 1);
                    RDY_RARE:   m_axis_tready = ($urandom_range(0, 7) == 0);
                    default:    m_axis_tready = ($urandom_range(0, 7) != 0);
                endcase
                @(negedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 8;
        gap_now       = GAP_RESET;
        phase_gap     = '{10'd0, 10'd1023, 10'd1000, GAP_RESET, 10'd20, 10'd1};
        phase_gap[4]  = GAP_WIDTH'($urandom_range(1, 999));
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset gap of 5 ms.
        send_pkt('1, '0, '1);                      // first packet, largest delay
        send_pkt(32'd4, 32'd4, 16'd0);             // arrival and seq both wrap, on time
        send_pkt(32'd9, 32'hFFFF_FFF0, 16'd1);     // send time ahead of arrival
        send_pkt(32'd9, 32'd9, 16'd1);             // zero gap, repeated seq
        send_pkt(32'd2, 32'd0, 16'd0);             // arrival earlier, seq goes back
        send_pkt(32'd1002, 32'd1000, 16'd100);     // long gap, seq jump
        send_pkt(32'd1006, 32'd0, 16'd101);        // gap one short of expected
        send_pkt('0, '0, '0);
        send_pkt('1, '1, '1);
        send_pkt(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
        send_pkt(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_gap(phase_gap[p]);
            cur_arrival = $urandom();
            cur_seq     = SEQ_WIDTH'($urandom());
            repeat (RANDOM_PER_PHASE) stream_pkt();
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
